// ===== hw/rtl/etp_pkg.sv =====
// shared constants, request and result types and helpers for the exclusive time profiler
package etp_pkg;

    localparam int NUM_FUNCS   = 16;
    localparam int STACK_DEPTH = 16;

    localparam int REQ_W  = 2;
    localparam int FID_W  = 4;
    localparam int TIME_W = 32;
    localparam int MARK_W = TIME_W + 1;

    localparam int IDX_W    = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
    localparam int SADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SCNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int ID_EXT_W = ((IDX_W > FID_W) ? IDX_W : FID_W) + 1;

    localparam logic [REQ_W-1:0] REQ_START  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_END    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

    localparam logic [TIME_W-1:0] TOTAL_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [FID_W-1:0]  func_id;
        logic [TIME_W-1:0] timestamp;
    } req_t;

    typedef struct packed {
        logic [FID_W-1:0]  func_id_out;
        logic [TIME_W-1:0] total_time;
        logic              last;
        logic              error;
    } rsp_t;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic             read_top;
        logic             clear;
        logic [FID_W-1:0] push_id;
    } stk_cmd_t;

    typedef struct packed {
        logic [SCNT_W-1:0] count;
        logic [FID_W-1:0]  top_id;
    } stk_sts_t;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_idx;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [TIME_W-1:0] wdata;
        logic              clear;
    } tot_cmd_t;

    function automatic logic id_valid(input logic [FID_W-1:0] id);
        return ID_EXT_W'(id) < ID_EXT_W'(NUM_FUNCS);
    endfunction

    function automatic logic [IDX_W-1:0] id_index(input logic [FID_W-1:0] id);
        logic [ID_EXT_W-1:0] ext;
        ext = ID_EXT_W'(id);
        return ext[IDX_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/etp_stack.sv =====
// call stack of function ids in a synchronous memory with its fill count
module etp_stack
    import etp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  stk_cmd_t cmd,
    output stk_sts_t sts
);

    logic [FID_W-1:0]   mem [STACK_DEPTH];
    logic [SCNT_W-1:0]  count_reg;
    logic [SCNT_W-1:0]  count_next;
    logic [FID_W-1:0]   top_reg;
    logic [SCNT_W-1:0]  top_cnt;
    logic [SADDR_W-1:0] top_addr;
    logic [SADDR_W-1:0] push_addr;

    assign top_cnt   = count_reg - SCNT_W'(1);
    assign top_addr  = top_cnt[SADDR_W-1:0];
    assign push_addr = count_reg[SADDR_W-1:0];

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + SCNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - SCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[push_addr] <= cmd.push_id;
        end
        if (cmd.read_top)
        begin
            top_reg <= mem[top_addr];
        end
    end

    assign sts.count  = count_reg;
    assign sts.top_id = top_reg;

endmodule

// ===== hw/rtl/etp_totals.sv =====
// exclusive time table in a synchronous memory, entries read as zero until written
module etp_totals
    import etp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tot_cmd_t          cmd,
    output logic [TIME_W-1:0] rdata
);

    logic [TIME_W-1:0]    mem [NUM_FUNCS];
    logic [NUM_FUNCS-1:0] valid_reg;
    logic [TIME_W-1:0]    rdata_reg;
    logic                 rvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                valid_reg <= '0;
            end
            else if (cmd.wr_en)
            begin
                valid_reg[cmd.wr_idx] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rvalid_reg <= valid_reg[cmd.rd_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_idx] <= cmd.wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[cmd.rd_idx];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== hw/rtl/exclusive_time_profiler_top.sv =====
// exclusive time profiler: request sequencer, mark time and result register
// a start on an empty stack is pushed in the accept cycle; other starts and ends step through
// accept, stack top read, total read, then write back, the steps set by the memory read ports
// an error waits in S_ERR for a free result slot, its result registered as it leaves
// a finish then reads and sends one function total at a time, NUM_FUNCS results in all
// reset is asynchronous: stack, mark time and totals are empty at once, no clearing pass
module exclusive_time_profiler_top
    import etp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_READ    = 6'b000010,
        S_TOT     = 6'b000100,
        S_ERR     = 6'b001000,
        S_FIN_RD  = 6'b010000,
        S_FIN_OUT = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [MARK_W-1:0] mark_reg, mark_next;
    logic [IDX_W-1:0]  fin_cnt_reg, fin_cnt_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_data_reg, out_data_next;

    stk_cmd_t          stk_cmd;
    stk_sts_t          stk_sts;
    tot_cmd_t          tot_cmd;
    logic [TIME_W-1:0] tot_rdata;

    logic              slot_free;
    logic              stk_empty;
    logic              stk_full;
    logic              commit;
    logic [MARK_W-1:0] t_eff;
    logic [MARK_W-1:0] elapsed;
    logic [MARK_W:0]   sum;
    logic [TIME_W-1:0] sum_sat;
    logic              fin_last;
    logic [ID_EXT_W-1:0] fin_id_ext;

    etp_stack u_stack
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (stk_cmd),
        .sts   (stk_sts)
    );

    etp_totals u_totals
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tot_cmd),
        .rdata (tot_rdata)
    );

    assign slot_free  = !out_valid_reg || out_ready;
    assign stk_empty  = (stk_sts.count == '0);
    assign stk_full   = (stk_sts.count == SCNT_W'(STACK_DEPTH));
    assign fin_last   = (fin_cnt_reg == IDX_W'(NUM_FUNCS - 1));
    assign fin_id_ext = ID_EXT_W'(fin_cnt_reg);

    // start charges up to the timestamp, end up to the tick after it
    assign t_eff   = (req_reg.req_type == REQ_START) ? {1'b0, req_reg.timestamp}
                   : ({1'b0, req_reg.timestamp} + MARK_W'(1));
    assign elapsed = (t_eff >= mark_reg) ? (t_eff - mark_reg) : '0;
    assign sum     = {2'b00, tot_rdata} + {1'b0, elapsed};
    assign sum_sat = (sum[MARK_W:TIME_W] != '0) ? TOTAL_MAX : sum[TIME_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        mark_next      = mark_reg;
        fin_cnt_next   = fin_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        stk_cmd        = '0;
        tot_cmd        = '0;
        commit         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = in_data;
                    case (in_data.req_type)
                        REQ_START:
                        begin
                            if (stk_full)
                            begin
                                state_next = S_ERR;
                            end
                            else if (stk_empty)
                            begin
                                stk_cmd.push    = 1'b1;
                                stk_cmd.push_id = in_data.func_id;
                                mark_next       = {1'b0, in_data.timestamp};
                            end
                            else
                            begin
                                stk_cmd.read_top = 1'b1;
                                state_next       = S_READ;
                            end
                        end
                        REQ_END:
                        begin
                            if (stk_empty)
                            begin
                                state_next = S_ERR;
                            end
                            else
                            begin
                                stk_cmd.read_top = 1'b1;
                                state_next       = S_READ;
                            end
                        end
                        REQ_FINISH:
                        begin
                            state_next = S_FIN_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (id_valid(stk_sts.top_id))
                begin
                    tot_cmd.rd_en  = 1'b1;
                    tot_cmd.rd_idx = id_index(stk_sts.top_id);
                    state_next     = S_TOT;
                end
                else
                begin
                    // time charged to an id outside the table is dropped
                    commit     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TOT:
            begin
                tot_cmd.wr_en  = 1'b1;
                tot_cmd.wr_idx = id_index(stk_sts.top_id);
                tot_cmd.wdata  = sum_sat;
                commit         = 1'b1;
                state_next     = S_IDLE;
            end
            S_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.func_id_out = (req_reg.req_type == REQ_START)
                                              ? req_reg.func_id : '0;
                    out_data_next.total_time  = '0;
                    out_data_next.last        = 1'b0;
                    out_data_next.error       = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            S_FIN_RD:
            begin
                tot_cmd.rd_en  = 1'b1;
                tot_cmd.rd_idx = fin_cnt_reg;
                state_next     = S_FIN_OUT;
            end
            S_FIN_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.func_id_out = fin_id_ext[FID_W-1:0];
                    out_data_next.total_time  = tot_rdata;
                    out_data_next.last        = fin_last;
                    out_data_next.error       = 1'b0;
                    if (fin_last)
                    begin
                        tot_cmd.clear = 1'b1;
                        stk_cmd.clear = 1'b1;
                        mark_next     = '0;
                        fin_cnt_next  = '0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        fin_cnt_next = fin_cnt_reg + IDX_W'(1);
                        state_next   = S_FIN_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (commit)
        begin
            mark_next = t_eff;
            if (req_reg.req_type == REQ_START)
            begin
                stk_cmd.push    = 1'b1;
                stk_cmd.push_id = req_reg.func_id;
            end
            else
            begin
                stk_cmd.pop = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mark_reg      <= '0;
            fin_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mark_reg      <= mark_next;
            fin_cnt_reg   <= fin_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== tb/tb.sv =====
// testbench for the exclusive time profiler: directed and random requests against a predictor
`timescale 1ns / 100ps

module tb
    import etp_pkg::*;
();

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 2 * NUM_FUNCS + 8;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_data;
    logic out_valid;
    logic out_ready;
    rsp_t out_data;

    logic [FID_W-1:0]  acc_stack [STACK_DEPTH];
    int                acc_depth;
    logic [MARK_W-1:0] acc_mark;
    logic [TIME_W-1:0] acc_total [NUM_FUNCS];

    rsp_t owed_results [$];
    int   promised;
    int   fail_count;
    int   in_idle_pct;
    int   out_idle_pct;
    int   hold_request;

    exclusive_time_profiler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic void clear_accounts();
        acc_depth = 0;
        acc_mark  = '0;
        for (int k = 0; k < NUM_FUNCS; k++)
            acc_total[k] = '0;
    endfunction

    function automatic void charge_total(input logic [FID_W-1:0] id, input logic [63:0] amount);
        logic [63:0] sum;
        if (int'(id) >= NUM_FUNCS)
            return;
        sum = 64'(acc_total[int'(id)]) + amount;
        if (sum > 64'(TOTAL_MAX))
            sum = 64'(TOTAL_MAX);
        acc_total[int'(id)] = sum[TIME_W-1:0];
    endfunction

    function automatic void account_request(input req_t r);
        rsp_t        rsp;
        logic [63:0] now;
        logic [63:0] spent;
        rsp = '0;
        now = 64'(r.timestamp);
        case (r.req_type)
            REQ_START:
            begin
                if (acc_depth >= STACK_DEPTH)
                begin
                    rsp.func_id_out = r.func_id;
                    rsp.error       = 1'b1;
                    owed_results.push_back(rsp);
                    promised++;
                end
                else
                begin
                    if (acc_depth > 0)
                    begin
                        spent = (now >= 64'(acc_mark)) ? now - 64'(acc_mark) : 64'd0;
                        charge_total(acc_stack[acc_depth-1], spent);
                    end
                    acc_stack[acc_depth] = r.func_id;
                    acc_depth++;
                    acc_mark = MARK_W'(now);
                end
            end
            REQ_END:
            begin
                now = now + 64'd1;
                if (acc_depth == 0)
                begin
                    rsp.error = 1'b1;
                    owed_results.push_back(rsp);
                    promised++;
                end
                else
                begin
                    spent = (now >= 64'(acc_mark)) ? now - 64'(acc_mark) : 64'd0;
                    charge_total(acc_stack[acc_depth-1], spent);
                    acc_depth--;
                    acc_mark = MARK_W'(now);
                end
            end
            REQ_FINISH:
            begin
                for (int k = 0; k < NUM_FUNCS; k++)
                begin
                    rsp.func_id_out = FID_W'(k);
                    rsp.total_time  = acc_total[k];
                    rsp.last        = (k == NUM_FUNCS - 1);
                    owed_results.push_back(rsp);
                    promised++;
                end
                clear_accounts();
            end
            default: ;
        endcase
    endfunction

    function automatic req_t make_req(input logic [REQ_W-1:0] kind, input logic [FID_W-1:0] id,
                                      input logic [TIME_W-1:0] stamp);
        req_t r;
        r.req_type  = kind;
        r.func_id   = id;
        r.timestamp = stamp;
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [TIME_W-1:0] want,
                                         input logic [TIME_W-1:0] got);
        if (got === want)
            return 0;
        $error("%s expected %0h got %0h", name, want, got);
        return 1;
    endfunction

    task automatic send_req(input req_t r);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (!in_ready);
        account_request(r);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: random stalls plus long hold-offs on request
    initial
    begin : result_accept
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    initial
    begin : result_check
        rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result with none owed: %p", out_data);
                    fail_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    fail_count += field_differs("func_id_out", TIME_W'(want.func_id_out),
                                                TIME_W'(out_data.func_id_out));
                    fail_count += field_differs("total_time", want.total_time,
                                                out_data.total_time);
                    fail_count += field_differs("last", TIME_W'(want.last),
                                                TIME_W'(out_data.last));
                    fail_count += field_differs("error", TIME_W'(want.error),
                                                TIME_W'(out_data.error));
                end
            end
        end
    end

    task automatic test_empty_stack_end();
        send_req(make_req(REQ_END, 4'h0, 32'h0000_0000));
    endtask

    task automatic test_unused_code();
        send_req(make_req(REQ_UNUSED, 4'hF, 32'hFFFF_FFFF));
    endtask

    // fill the stack, overflow it, then finish with every call still open
    task automatic test_full_stack();
        logic [TIME_W-1:0] stamp;
        for (int k = 0; k < STACK_DEPTH; k++)
        begin
            stamp = (k == 5) ? TIME_W'(7) : TIME_W'(10 * k + 3);
            send_req(make_req(REQ_START, FID_W'(k), stamp));
        end
        send_req(make_req(REQ_START, 4'hA, 32'd500));
        send_req(make_req(REQ_FINISH, 4'h0, 32'd600));
    endtask

    // total saturation, then an end whose time runs backwards
    task automatic test_time_saturation();
        send_req(make_req(REQ_START, 4'h3, 32'h0000_0000));
        send_req(make_req(REQ_END, 4'h3, 32'hFFFF_FFFF));
        send_req(make_req(REQ_START, 4'h9, 32'h0000_0010));
        send_req(make_req(REQ_END, 4'h9, 32'h0000_0005));
        send_req(make_req(REQ_FINISH, 4'hC, 32'h8000_0000));
    endtask

    task automatic run_random_calls(input int count);
        int                sent;
        int                roll;
        bit                climbing;
        bit                do_start;
        logic [TIME_W-1:0] tick;
        sent     = 0;
        climbing = 1'b1;
        tick     = $urandom;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 10)
                climbing = ~climbing;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                tick = tick - $urandom_range(1, 200);
            else if (roll < 6)
                tick = $urandom;
            else if (roll < 10)
                tick = tick + $urandom;
            else
                tick = tick + $urandom_range(0, 40);
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                send_req(make_req(REQ_UNUSED, FID_W'($urandom), tick));
                continue;
            end
            if (roll < 7)
            begin
                send_req(make_req(REQ_FINISH, FID_W'($urandom), tick));
                sent++;
                continue;
            end
            do_start = climbing ? ($urandom_range(0, 99) < 80) : ($urandom_range(0, 99) < 30);
            if (acc_depth == 0 && $urandom_range(0, 99) < 85)
                do_start = 1'b1;
            if (acc_depth >= STACK_DEPTH && $urandom_range(0, 99) < 70)
                do_start = 1'b0;
            send_req(make_req(do_start ? REQ_START : REQ_END, FID_W'($urandom), tick));
            sent++;
        end
    endtask

    task automatic test_random_calls();
        run_random_calls(110);
    endtask

    task automatic test_back_to_back();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_random_calls(40);
        in_idle_pct  = 30;
        out_idle_pct = 30;
    endtask

    // receiver holds off while finishes and error requests keep coming
    task automatic test_output_backpressure();
        hold_request = 250;
        send_req(make_req(REQ_FINISH, 4'h1, 32'd0));
        send_req(make_req(REQ_END, 4'h2, 32'd1));
        send_req(make_req(REQ_START, 4'h4, 32'd2));
        send_req(make_req(REQ_START, 4'hB, 32'd9));
        send_req(make_req(REQ_END, 4'hB, 32'd20));
        send_req(make_req(REQ_FINISH, 4'h0, 32'd30));
        send_req(make_req(REQ_END, 4'h7, 32'd31));
        send_req(make_req(REQ_FINISH, 4'h0, 32'd40));
    endtask

    initial
    begin
        fail_count   = 0;
        promised     = 0;
        hold_request = 0;
        in_idle_pct  = 30;
        out_idle_pct = 30;
        clear_accounts();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_stack_end();
        test_unused_code();
        test_full_stack();
        test_time_saturation();
        test_random_calls();
        test_back_to_back();
        test_output_backpressure();
        drain_results();
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/etp_pkg.sv
hw/rtl/etp_stack.sv
hw/rtl/etp_totals.sv
hw/rtl/exclusive_time_profiler_top.sv
tb/tb.sv
